### design/autokey_letter_cipher_defines.svh
// Assertion macros shared by the autokey letter cipher modules.
`ifndef AUTOKEY_LETTER_CIPHER_DEFINES_SVH
`define AUTOKEY_LETTER_CIPHER_DEFINES_SVH

// Check a condition that holds in the same cycle as its trigger.
`define AKLC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition that holds in the cycle after its trigger.
`define AKLC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/aklc_pkg.sv
// Package with types, constants and helpers of the autokey letter cipher.
package aklc_pkg;

  localparam int ALPHABET        = 26;
  localparam int MAX_KEY_LETTERS = 12;
  localparam int LETTER_W        = 5;
  localparam int PTR_W           = 4;
  localparam int KEY_LETTERS_W   = 60;
  localparam int KEY_LEN_W       = 4;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QUEUE_CNT_W     = 2;
  localparam int APB_ADDR_W      = 5;
  localparam int APB_DATA_W      = 64;
  localparam int REG_IDX_W       = 2;

  localparam logic [REG_IDX_W-1:0] REG_KEY_LETTERS = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEY_LENGTH  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MODE        = 2'd2;

  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [PTR_W-1:0]    ptr_t;

  typedef struct packed {
    logic [KEY_LETTERS_W-1:0] key_letters;
    logic [KEY_LEN_W-1:0]     key_length;
    logic                     mode;
  } cfg_t;

  typedef struct packed {
    letter_t letter;
    ptr_t    pos;
    logic    use_history;
    letter_t primer_key;
    logic    mode;
  } work_t;

  function automatic letter_t fold_letter(input letter_t x);
    return (x >= LETTER_W'(ALPHABET)) ? x - LETTER_W'(ALPHABET) : x;
  endfunction

  function automatic ptr_t active_length(input logic [KEY_LEN_W-1:0] n);
    ptr_t len;
    len = PTR_W'(n);
    if (n == '0) begin
      len = PTR_W'(1);
    end else if (n > KEY_LEN_W'(MAX_KEY_LETTERS)) begin
      len = PTR_W'(MAX_KEY_LETTERS);
    end
    return len;
  endfunction

endpackage

### design/aklc_channels.sv
// Handshake interfaces for the letter input and letter output channels.
interface aklc_in_if import aklc_pkg::*; ();
  logic    valid;
  logic    ready;
  letter_t letter_in;
  logic    msg_start;

  modport source(output valid, output letter_in, output msg_start, input ready);
  modport sink(input valid, input letter_in, input msg_start, output ready);
endinterface

interface aklc_out_if import aklc_pkg::*; ();
  logic    valid;
  logic    ready;
  letter_t letter_out;

  modport source(output valid, output letter_out, input ready);
  modport sink(input valid, input letter_out, output ready);
endinterface

### design/aklc_front.sv
// Front end: accepts letters, tracks key stream position and primer keys.
`include "autokey_letter_cipher_defines.svh"

module aklc_front import aklc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  aklc_in_if.sink     letters,
  input  cfg_t        cfg,
  input  logic        queue_full,
  output logic        push,
  output work_t       push_data
);

  ptr_t ptr;
  ptr_t ptr_next;
  logic past;
  logic past_next;
  ptr_t cur_ptr;
  logic cur_past;
  ptr_t len;
  ptr_t pos_inc;

  assign letters.ready = !queue_full;
  assign push          = letters.valid && letters.ready;

  always_comb begin
    len      = active_length(cfg.key_length);
    cur_ptr  = letters.msg_start ? '0 : ptr;
    cur_past = letters.msg_start ? 1'b0 : past;
    pos_inc  = cur_ptr + PTR_W'(1);
    if (pos_inc >= len) begin
      ptr_next  = '0;
      past_next = 1'b1;
    end else begin
      ptr_next  = pos_inc;
      past_next = cur_past;
    end
    push_data.letter      = fold_letter(letters.letter_in);
    push_data.pos         = cur_ptr;
    push_data.use_history = cur_past;
    push_data.primer_key  = fold_letter(cfg.key_letters[LETTER_W*int'(cur_ptr) +: LETTER_W]);
    push_data.mode        = cfg.mode;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr  <= '0;
      past <= 1'b0;
    end else if (push) begin
      ptr  <= ptr_next;
      past <= past_next;
    end
  end

  `AKLC_ASSERT_SAME(a_ptr_in_ring, 1'b1, ptr < PTR_W'(MAX_KEY_LETTERS),
    "key stream pointer left the ring")

endmodule

### design/aklc_queue.sv
// Short queue of work items between the front end and the back end.
`include "autokey_letter_cipher_defines.svh"

module aklc_queue import aklc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t push_data,
  output logic  full,
  output logic  pop_valid,
  input  logic  pop,
  output work_t pop_data
);

  work_t                  slots [QUEUE_DEPTH];
  logic                   wr_ptr;
  logic                   rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign full      = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      priority if (push && !pop) begin
        count <= count + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QUEUE_CNT_W'(1);
      end
    end
  end

  `AKLC_ASSERT_SAME(a_count_bound, 1'b1, count <= QUEUE_CNT_W'(QUEUE_DEPTH),
    "queue count above depth")
  `AKLC_ASSERT_SAME(a_no_pop_empty, pop, count != '0,
    "pop from an empty queue")

endmodule

### design/aklc_back.sv
// Back end: history ring, modular add or subtract, and the output register.
`include "autokey_letter_cipher_defines.svh"

module aklc_back import aklc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       work_valid,
  input  work_t      work,
  output logic       pop,
  aklc_out_if.source results
);

  letter_t              history [MAX_KEY_LETTERS];
  letter_t              key;
  letter_t              plain;
  letter_t              result;
  logic [LETTER_W:0]    sum;
  logic [LETTER_W:0]    diff;
  logic                 out_valid;
  letter_t              out_letter;

  assign pop                = work_valid && (!out_valid || results.ready);
  assign results.valid      = out_valid;
  assign results.letter_out = out_letter;

  always_comb begin
    key  = work.use_history ? history[work.pos] : work.primer_key;
    sum  = {1'b0, work.letter} + {1'b0, key};
    diff = {1'b0, work.letter} + (LETTER_W+1)'(ALPHABET) - {1'b0, key};
    if (work.mode == MODE_DECRYPT) begin
      plain  = (diff >= (LETTER_W+1)'(ALPHABET)) ?
               LETTER_W'(diff - (LETTER_W+1)'(ALPHABET)) : LETTER_W'(diff);
      result = plain;
    end else begin
      plain  = work.letter;
      result = (sum >= (LETTER_W+1)'(ALPHABET)) ?
               LETTER_W'(sum - (LETTER_W+1)'(ALPHABET)) : LETTER_W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      history[work.pos] <= plain;
      out_letter        <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  `AKLC_ASSERT_SAME(a_out_letter_range, out_valid, out_letter < LETTER_W'(ALPHABET),
    "output letter outside the alphabet")
  `AKLC_ASSERT_NEXT(a_pop_fills_output, pop, out_valid,
    "popped item did not reach the output register")

endmodule

### design/autokey_letter_cipher.sv
// Top level of the autokey letter cipher: config registers, front, queue, back.
//
// Usage:
//   letters: one letter code (0..25, higher codes folded by 26) per transaction,
//     with msg_start high on the first letter of a message to restart the key.
//   results: one letter code per accepted input letter, in order.
//   APB port: key_letters at 0x00, key_length at 0x08, mode at 0x10, 64-bit data.
//     Write registers only while no letters are in flight.
// Path: an accepted letter is written into a queue slot, then popped into the
//   output register that drives results when the queue is empty and the output is free.
// Throughput: one letter per cycle while results.ready stays high; set by the
//   read, add or subtract, and write of the plaintext history ring in the back end.
// Reset: synchronous; clears the key stream position, queue and output valid,
//   and loads key_letters 0, key_length 1, mode encrypt.
// Stall: while results.ready is low the output register holds, the two-entry
//   queue fills, and letters.ready drops once the queue is full.
module autokey_letter_cipher import aklc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  aklc_in_if.sink               letters,
  aklc_out_if.source            results,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t                 cfg;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_write;
  logic                 push;
  work_t                push_data;
  logic                 queue_full;
  logic                 work_valid;
  work_t                work;
  logic                 pop;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_letters <= '0;
      cfg.key_length  <= KEY_LEN_W'(1);
      cfg.mode        <= MODE_ENCRYPT;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_KEY_LETTERS: cfg.key_letters <= pwdata[KEY_LETTERS_W-1:0];
        REG_KEY_LENGTH:  cfg.key_length  <= pwdata[KEY_LEN_W-1:0];
        REG_MODE:        cfg.mode        <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_KEY_LETTERS: prdata = APB_DATA_W'(cfg.key_letters);
      REG_KEY_LENGTH:  prdata = APB_DATA_W'(cfg.key_length);
      REG_MODE:        prdata = APB_DATA_W'(cfg.mode);
      default:         prdata = '0;
    endcase
  end

  aklc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .letters    (letters),
    .cfg        (cfg),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  aklc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop_valid (work_valid),
    .pop       (pop),
    .pop_data  (work)
  );

  aklc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .work_valid (work_valid),
    .work       (work),
    .pop        (pop),
    .results    (results)
  );

endmodule
